>>> hdl/quaternion_to_rotation_matrix_assert.svh
// Assertion macros for the quaternion to rotation matrix block.
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define QRM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define QRM_ASSERT_IMP(label, clk, rst, ante, cons)
`define QRM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/qrm_pkg.sv
// Shared types and constants for the quaternion to rotation matrix block.
package qrm_pkg;

   localparam int COMP_W = 16;
   localparam int NORM_W = 33;
   localparam int DIV_STEPS = 16;
   localparam logic signed [COMP_W-1:0] ONE_Q14 = 16'sd16384;
   localparam logic signed [COMP_W-1:0] NEG_ONE_Q14 = -16'sd16384;

   typedef struct packed {
      logic signed [COMP_W-1:0] quat_x;
      logic signed [COMP_W-1:0] quat_y;
      logic signed [COMP_W-1:0] quat_z;
      logic signed [COMP_W-1:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] m00;
      logic signed [COMP_W-1:0] m01;
      logic signed [COMP_W-1:0] m02;
      logic signed [COMP_W-1:0] m10;
      logic signed [COMP_W-1:0] m11;
      logic signed [COMP_W-1:0] m12;
      logic signed [COMP_W-1:0] m20;
      logic signed [COMP_W-1:0] m21;
      logic signed [COMP_W-1:0] m22;
      logic                     zero_norm;
   } rsp_type;

endpackage

>>> hdl/qrm_div_lane.sv
// Pipelined restoring divider lane: floor(mag * 2^15 / den), one quotient bit per stage.
module qrm_div_lane
   import qrm_pkg::*;
(
   input  logic                clock,
   input  logic                advance,
   input  logic [NORM_W-1:0]   mag,
   input  logic [NORM_W-1:0]   den,
   output logic [DIV_STEPS-1:0] quot
);

   logic [NORM_W-1:0]    rem_ff [DIV_STEPS];
   logic [NORM_W-1:0]    den_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS];

   logic                 first_bit;
   logic [NORM_W-1:0]    first_rem_in;

   // mag never exceeds den, so the top bit decides alone
   always_comb begin
      first_bit    = (mag >= den);
      first_rem_in = first_bit ? (mag - den) : mag;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= first_rem_in;
         den_ff[0] <= den;
         quo_ff[0] <= {{(DIV_STEPS-1){1'b0}}, first_bit};
      end
   end

   for (genvar k = 1; k < DIV_STEPS; k++) begin : g_step
      logic [NORM_W:0]   dbl;
      logic              bit_q;
      logic [NORM_W-1:0] rem_in;

      always_comb begin
         dbl    = {rem_ff[k-1], 1'b0};
         bit_q  = (dbl >= {1'b0, den_ff[k-1]});
         rem_in = bit_q ? NORM_W'(dbl - {1'b0, den_ff[k-1]}) : dbl[NORM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= {quo_ff[k-1][DIV_STEPS-2:0], bit_q};
         end
      end
   end

   assign quot = quo_ff[DIV_STEPS-1];

endmodule

>>> hdl/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix: top level and pipeline control.
// Usage notes:
//   req channel carries one quaternion (x, y, z, w, signed Q2.14) per beat;
//   rsp channel returns the nine matrix entries (Q2.14) and a zero_norm flag.
//   Each entry is the product term divided by the squared norm, rounded to
//   nearest with ties away from zero and held within plus or minus one.
//   A zero quaternion gives the identity matrix with zero_norm set.
// Timing:
//   The pipeline has one multiply stage, one sum stage, sixteen divider
//   stages (one quotient bit each, nine lanes in parallel) and the output
//   register. A new beat may enter every cycle while req_stall is low.
// Reset:
//   synchronous reset clears every valid bit; the pipeline comes up empty.
// Back-pressure:
//   when rsp_stall holds a waiting result, the whole pipeline freezes and
//   req_stall is raised; nothing is dropped or repeated.
`include "quaternion_to_rotation_matrix_assert.svh"
module quaternion_to_rotation_matrix
   import qrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int LAT = DIV_STEPS + 3;

   logic [LAT-1:0] valid_ff, valid_in;
   logic           advance;

   assign advance   = !(valid_ff[LAT-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[LAT-1];

   always_comb valid_in = advance ? {valid_ff[LAT-2:0], req_valid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   // stage 1: products
   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [31:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         xx_ff <= req_data.quat_x * req_data.quat_x;
         yy_ff <= req_data.quat_y * req_data.quat_y;
         zz_ff <= req_data.quat_z * req_data.quat_z;
         ww_ff <= req_data.quat_w * req_data.quat_w;
         xy_ff <= req_data.quat_x * req_data.quat_y;
         xz_ff <= req_data.quat_x * req_data.quat_z;
         yz_ff <= req_data.quat_y * req_data.quat_z;
         wx_ff <= req_data.quat_w * req_data.quat_x;
         wy_ff <= req_data.quat_w * req_data.quat_y;
         wz_ff <= req_data.quat_w * req_data.quat_z;
      end
   end

   // stage 2: norm, numerators, magnitudes
   logic signed [34:0] sxx, syy, szz, sww, sxy, sxz, syz, swx, swy, swz;
   logic signed [34:0] num [9];
   logic [NORM_W-1:0]  norm_in;
   logic [NORM_W-1:0]  mag_in [9];
   logic [8:0]         neg_in;

   always_comb begin
      sxx = 35'(xx_ff);
      syy = 35'(yy_ff);
      szz = 35'(zz_ff);
      sww = 35'(ww_ff);
      sxy = 35'(xy_ff);
      sxz = 35'(xz_ff);
      syz = 35'(yz_ff);
      swx = 35'(wx_ff);
      swy = 35'(wy_ff);
      swz = 35'(wz_ff);
      norm_in = NORM_W'(sxx + syy + szz + sww);
      num[0] = sww + sxx - syy - szz;
      num[1] = (sxy + swz) <<< 1;
      num[2] = (sxz - swy) <<< 1;
      num[3] = (sxy - swz) <<< 1;
      num[4] = sww - sxx + syy - szz;
      num[5] = (syz + swx) <<< 1;
      num[6] = (sxz + swy) <<< 1;
      num[7] = (syz - swx) <<< 1;
      num[8] = sww - sxx - syy + szz;
      for (int i = 0; i < 9; i++) begin
         neg_in[i] = num[i][34];
         mag_in[i] = neg_in[i] ? NORM_W'(-num[i]) : NORM_W'(num[i]);
      end
   end

   logic [NORM_W-1:0] norm_ff;
   logic [NORM_W-1:0] mag_ff [9];
   logic [8:0]        neg_ff;
   logic              zero_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         norm_ff <= norm_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         zero_ff <= (norm_in == '0);
      end
   end

   // sign and zero flag ride alongside the divider lanes
   logic [9:0] side_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= {zero_ff, neg_ff};
         for (int k = 1; k < DIV_STEPS; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   logic [DIV_STEPS-1:0] quot [9];

   for (genvar i = 0; i < 9; i++) begin : g_lane
      qrm_div_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .mag     (mag_ff[i]),
         .den     (norm_ff),
         .quot    (quot[i])
      );
   end

   // output stage: round, saturate, sign, identity for a zero norm
   logic signed [COMP_W-1:0] ent [9];
   logic [DIV_STEPS:0]       rnd [9];
   logic [COMP_W-1:0]        mag_q [9];
   logic                     zero_out;
   rsp_type                  rsp_in, rsp_ff;

   always_comb begin
      zero_out = side_ff[DIV_STEPS-1][9];
      for (int i = 0; i < 9; i++) begin
         rnd[i]   = ({1'b0, quot[i]} + 17'd1) >> 1;
         mag_q[i] = (rnd[i] > 17'(ONE_Q14)) ? ONE_Q14 : rnd[i][COMP_W-1:0];
         ent[i]   = side_ff[DIV_STEPS-1][i] ? -$signed(mag_q[i]) : $signed(mag_q[i]);
         if (zero_out) ent[i] = (i == 0 || i == 4 || i == 8) ? ONE_Q14 : '0;
      end
      rsp_in.m00       = ent[0];
      rsp_in.m01       = ent[1];
      rsp_in.m02       = ent[2];
      rsp_in.m10       = ent[3];
      rsp_in.m11       = ent[4];
      rsp_in.m12       = ent[5];
      rsp_in.m20       = ent[6];
      rsp_in.m21       = ent[7];
      rsp_in.m22       = ent[8];
      rsp_in.zero_norm = zero_out;
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `QRM_ASSERT_IMP(a_identity, clock, reset, rsp_valid && rsp_data.zero_norm, rsp_data.m00 == ONE_Q14 && rsp_data.m11 == ONE_Q14 && rsp_data.m22 == ONE_Q14 && rsp_data.m01 == 16'sd0 && rsp_data.m12 == 16'sd0)
   `QRM_ASSERT_IMP(a_range, clock, reset, rsp_valid, rsp_data.m00 <= ONE_Q14 && rsp_data.m00 >= NEG_ONE_Q14 && rsp_data.m12 <= ONE_Q14 && rsp_data.m12 >= NEG_ONE_Q14)
   `QRM_ASSERT_NXT(a_freeze, clock, reset, rsp_valid && rsp_stall, $stable(valid_ff))

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the quaternion to rotation matrix block.
module tb_top
   import qrm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 19;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS = 10;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type matrix_queue[$];
   int      mismatch_count = 0;
   int      sender_idle_pct;
   int      receiver_stall_pct;
   bit      hold_off;
   int      idle_cycles;

   quaternion_to_rotation_matrix DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // round-to-nearest division by the squared norm, ties away from zero
   function automatic logic signed [15:0] scale_q14(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag * 16384 + den) / (2 * den);
      if (q > 16384) q = 16384;
      return (num < 0) ? 16'(-q) : 16'(q);
   endfunction

   function automatic rsp_type rotation_of(req_type q);
      rsp_type r;
      longint x, y, z, w, xx, yy, zz, ww, n;
      x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
      xx = x * x; yy = y * y; zz = z * z; ww = w * w;
      n = xx + yy + zz + ww;
      r = '0;
      if (n == 0) begin
         r.m00 = ONE_Q14;
         r.m11 = ONE_Q14;
         r.m22 = ONE_Q14;
         r.zero_norm = 1'b1;
      end else begin
         r.m00 = scale_q14(ww + xx - yy - zz, n);
         r.m01 = scale_q14(2*x*y + 2*w*z, n);
         r.m02 = scale_q14(2*x*z - 2*w*y, n);
         r.m10 = scale_q14(2*x*y - 2*w*z, n);
         r.m11 = scale_q14(ww - xx + yy - zz, n);
         r.m12 = scale_q14(2*y*z + 2*w*x, n);
         r.m20 = scale_q14(2*x*z + 2*w*y, n);
         r.m21 = scale_q14(2*y*z - 2*w*x, n);
         r.m22 = scale_q14(ww - xx - yy + zz, n);
      end
      return r;
   endfunction

   // receiver: random stall, or a held stretch when hold_off is set
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type exp_m;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (matrix_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat %p", rsp_data);
         end else begin
            exp_m = matrix_queue.pop_front();
            if (rsp_data !== exp_m) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected %p actual %p", exp_m, rsp_data);
            end
         end
      end
   end

   // watchdog on cycles with no accepted beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_quat(req_type q);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      matrix_queue.push_back(rotation_of(q));
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   function automatic req_type random_quat();
      req_type q;
      logic [15:0] c[4];
      int shape;
      shape = $urandom_range(9);
      foreach (c[i]) begin
         c[i] = 16'($urandom);
         if (shape == 0) c[i] = 16'($signed(16'($urandom_range(7))) - 3);
         else if (shape == 1 && $urandom_range(1)) c[i] = '0;
         else if (shape == 2) c[i] = 16'($urandom_range(1) ? 16'h8000 : 16'h7fff);
      end
      q.quat_x = c[0]; q.quat_y = c[1]; q.quat_z = c[2]; q.quat_w = c[3];
      return q;
   endfunction

   task automatic test_directed();
      req_type q;
      logic signed [15:0] vals[7] = '{16'sh0000, 16'sh4000, -16'sh4000, 16'sh7fff,
                                      -16'sh8000, 16'sh0001, -16'sh0001};
      sender_idle_pct = 0; receiver_stall_pct = 0;
      send_quat('0);
      for (int i = 0; i < 7; i++) begin
         q = '0; q.quat_w = vals[i]; q.quat_x = vals[(i + 3) % 7];
         q.quat_y = vals[(i + 5) % 7]; q.quat_z = vals[(i + 1) % 7];
         send_quat(q);
      end
      q = '{16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000}; send_quat(q);
      q = '{16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000}; send_quat(q);
      q = '{16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000}; send_quat(q);
      q = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000}; send_quat(q);
      q = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}; send_quat(q);
      // tiny norms: coarse quotients through the rounding step
      q = '{16'sh0001, 16'sh0001, 16'sh0000, 16'sh0001}; send_quat(q);
      q = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000}; send_quat(q);
      q = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001}; send_quat(q);
      release_req();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      sender_idle_pct = idle_pct; receiver_stall_pct = stall_pct;
      repeat (count) send_quat(random_quat());
      release_req();
   endtask

   task automatic test_backpressure();
      sender_idle_pct = 0; receiver_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (80) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (60) send_quat(random_quat());
      join
      release_req();
   endtask

   initial begin
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      hold_off = 1'b0;
      sender_idle_pct = 0; receiver_stall_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(450, 0, 0);
      test_random(450, 65, 0);
      test_random(450, 0, 65);
      test_backpressure();
      test_random(440, 19, 19);
      sender_idle_pct = 0; receiver_stall_pct = 0;
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (mismatch_count == 0 && matrix_queue.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hdl
hdl/qrm_pkg.sv
hdl/qrm_div_lane.sv
hdl/quaternion_to_rotation_matrix.sv
dv/tb_top.sv
